@@ rtl/evl_pkg.sv @@
// Shared types and codes for the overwrite-oldest event log.
// No dependencies; imported by every module of the block.
`default_nettype none

package evl_pkg;

    // Fixed field widths of the request and result channels
    localparam int FUNC_W    = 2;
    localparam int LEVEL_W   = 3;
    localparam int WORD_W    = 32;
    localparam int OFF_W     = 6;
    localparam int ENTRIES_W = 7;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // One stored ring entry
    typedef struct packed {
        logic [WORD_W-1:0]  seq;
        logic [WORD_W-1:0]  wall_time;
        logic [WORD_W-1:0]  uptime;
        logic [LEVEL_W-1:0] level;
        logic [WORD_W-1:0]  payload;
    } entry_t;

    // Entry RAM access strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_cmd_t;

    // Result of one request as decided by the pointer control
    typedef struct packed {
        logic                 found;
        logic                 from_ram;
        entry_t               entry;
        logic [ENTRIES_W-1:0] count;
    } res_info_t;

endpackage

`default_nettype wire

@@ rtl/evl_entry_ram.sv @@
// Single-port entry RAM of the event ring, with a registered read.
// Depends on evl_pkg for entry_t and ram_cmd_t.
`default_nettype none

module evl_entry_ram
    import evl_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire ram_cmd_t          cmd,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire entry_t            wdata,
    output entry_t                 rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write on add, read on read hit; the two never coincide
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[addr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/evl_ptr_ctrl.sv @@
// Ring pointers, fill count and sequence counter; slot address decode.
// Depends on evl_pkg; drives the entry RAM and the result register.
`default_nettype none

module evl_ptr_ctrl
    import evl_pkg::*;
#(
    parameter int RING_DEPTH = 64,
    parameter int PTR_W      = 6
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [LEVEL_W-1:0] event_level,
    input  wire logic [WORD_W-1:0]  wall_time,
    input  wire logic [WORD_W-1:0]  uptime_secs,
    input  wire logic [WORD_W-1:0]  payload_word,
    input  wire logic [OFF_W-1:0]   newest_offset,
    output ram_cmd_t                ram_cmd,
    output logic [PTR_W-1:0]        ram_addr,
    output entry_t                  wr_entry,
    output res_info_t               res
);

    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = (CNT_W > OFF_W) ? CNT_W : OFF_W;
    localparam int SUM_W = PTR_W + 1;

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [WORD_W-1:0] seq_reg, seq_next;

    logic              full;
    logic              hit;
    logic [WORD_W-1:0] seq_inc;
    logic [PTR_W-1:0]  head_inc;
    logic [CMP_W-1:0]  fill_ext, off_ext, rev_idx;
    logic [SUM_W-1:0]  tail_sum, read_sum;
    logic [PTR_W-1:0]  slot_tail, slot_read;

    // Sequence number skips zero on wrap
    assign seq_inc = (seq_reg == '1) ? WORD_W'(1) : (seq_reg + WORD_W'(1));

    assign full     = (fill_reg == CNT_W'(RING_DEPTH));
    assign head_inc = (head_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : (head_reg + PTR_W'(1));

    // Tail slot: head + fill, wrapped once (fill below depth when not full)
    assign tail_sum  = {1'b0, head_reg} + {1'b0, fill_reg[PTR_W-1:0]};
    assign slot_tail = (tail_sum >= SUM_W'(RING_DEPTH))
                     ? PTR_W'(tail_sum - SUM_W'(RING_DEPTH)) : tail_sum[PTR_W-1:0];

    // Read slot: head + fill - 1 - offset, wrapped once
    assign fill_ext  = CMP_W'(fill_reg);
    assign off_ext   = CMP_W'(newest_offset);
    assign hit       = (off_ext < fill_ext);
    assign rev_idx   = fill_ext - CMP_W'(1) - off_ext;
    assign read_sum  = {1'b0, head_reg} + {1'b0, rev_idx[PTR_W-1:0]};
    assign slot_read = (read_sum >= SUM_W'(RING_DEPTH))
                     ? PTR_W'(read_sum - SUM_W'(RING_DEPTH)) : read_sum[PTR_W-1:0];

    // Entry written by an add
    always_comb begin
        wr_entry.seq       = seq_reg;
        wr_entry.wall_time = wall_time;
        wr_entry.uptime    = uptime_secs;
        wr_entry.level     = event_level;
        wr_entry.payload   = payload_word;
    end

    // Decode the request: pointer updates, RAM access, result
    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        seq_next  = seq_reg;
        ram_cmd   = '0;
        ram_addr  = slot_tail;
        res       = '0;
        unique case (func)
            FUNC_ADD: begin
                ram_cmd.wr_en = accept;
                seq_next      = seq_inc;
                if (full) begin
                    ram_addr  = head_reg;
                    head_next = head_inc;
                end else begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                res.found = 1'b1;
                res.entry = wr_entry;
            end
            FUNC_READ: begin
                ram_addr = slot_read;
                if (hit) begin
                    ram_cmd.rd_en = accept;
                    res.found     = 1'b1;
                    res.from_ram  = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                head_next = '0;
                fill_next = '0;
            end
            default: begin
            end
        endcase
        res.count = ENTRIES_W'(fill_next);
    end

    // Advance state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
            seq_reg  <= WORD_W'(1);
        end else if (accept) begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            seq_reg  <= seq_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/overwrite_ring_event_log_core.sv @@
// Top level of the overwrite-oldest event log: handshake and result register.
// Depends on evl_pkg, evl_ptr_ctrl and evl_entry_ram.
`default_nettype none

// Event ring of RING_DEPTH entries that overwrites the oldest entry when full.
// Every request (add, read by distance from the newest, clear) gives one
// result in the cycle after it is accepted, and a new request is taken every
// cycle while the result side keeps up: outside reset, s_ready is high
// whenever the result register is empty or being drained. Entries live in a
// single-port RAM with a registered read; an add writes it at the accepting
// edge and a read hit reads it there, so a read right after an add already
// sees the new entry. Clear only resets the pointers and the count; the RAM
// is not swept, and the sequence counter keeps running across clears.
module overwrite_ring_event_log_core
    import evl_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [FUNC_W-1:0]    s_func,
    input  wire logic [LEVEL_W-1:0]   s_event_level,
    input  wire logic [WORD_W-1:0]    s_wall_time,
    input  wire logic [WORD_W-1:0]    s_uptime_secs,
    input  wire logic [WORD_W-1:0]    s_payload_word,
    input  wire logic [OFF_W-1:0]     s_newest_offset,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_found,
    output logic [WORD_W-1:0]         m_seq_out,
    output logic [WORD_W-1:0]         m_time_out,
    output logic [WORD_W-1:0]         m_uptime_out,
    output logic [LEVEL_W-1:0]        m_level_out,
    output logic [WORD_W-1:0]         m_payload_out,
    output logic [ENTRIES_W-1:0]      m_entries_held
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic             accept;
    ram_cmd_t         ram_cmd;
    logic [PTR_W-1:0] ram_addr;
    entry_t           wr_entry;
    entry_t           ram_rdata;
    res_info_t        res;

    logic      m_valid_reg, m_valid_next;
    res_info_t res_reg;
    entry_t    out_entry;

    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    evl_ptr_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .PTR_W      (PTR_W)
    ) u_ptr_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .func          (s_func),
        .event_level   (s_event_level),
        .wall_time     (s_wall_time),
        .uptime_secs   (s_uptime_secs),
        .payload_word  (s_payload_word),
        .newest_offset (s_newest_offset),
        .ram_cmd       (ram_cmd),
        .ram_addr      (ram_addr),
        .wr_entry      (wr_entry),
        .res           (res)
    );

    evl_entry_ram #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_entry_ram (
        .aclk  (aclk),
        .cmd   (ram_cmd),
        .addr  (ram_addr),
        .wdata (wr_entry),
        .rdata (ram_rdata)
    );

    // Hold the result until the request is taken downstream
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture result info on accept; RAM read data stays put until next read
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

    // Select RAM data for read hits, held fields otherwise
    assign out_entry = res_reg.from_ram ? ram_rdata : res_reg.entry;

    assign m_valid        = m_valid_reg;
    assign m_found        = res_reg.found;
    assign m_seq_out      = out_entry.seq;
    assign m_time_out     = out_entry.wall_time;
    assign m_uptime_out   = out_entry.uptime;
    assign m_level_out    = out_entry.level;
    assign m_payload_out  = out_entry.payload;
    assign m_entries_held = res_reg.count;

endmodule

`default_nettype wire
